### rtl/core/assert_macros.svh
// Assertion helper macros used by the SCC port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

### rtl/core/scc_pkg.sv
// ---------------------------------------------------------------------------
// SCC package
// Shared constants, opcodes and state type for the component finder.
// ---------------------------------------------------------------------------
package scc_pkg;
   localparam int MaxVertices = 64;
   localparam int MaxEdges    = 256;
   localparam int VW = $clog2(MaxVertices);
   localparam int EW = $clog2(MaxEdges);
   localparam int CW = EW + 1;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0, OP_RUN = 2'd1, OP_CLEAR = 2'd2, OP_NONE = 2'd3
   } opcode_type;

   typedef enum logic [4:0] {
      S_IDLE, S_SORT, S_SORT_WAIT, S_P1_ROOT, S_TOP, S_SCAN, S_SCAN_IDX, S_SCAN_WAIT,
      S_P2_CLR, S_P2_ROOT, S_P2_ROOT_WAIT, S_EMIT
   } state_type;
endpackage

### rtl/core/scc_edge_ram.sv
// ---------------------------------------------------------------------------
// SCC RAM
// Generic memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
module scc_edge_ram #(
   parameter int Depth = 256,
   parameter int Width = 12
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // Synchronous write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### rtl/core/strongly_connected_components_top.sv
// A run sorts the stored edges by source, then walks the edges in a first
// and a second pass, popping saved stack frames, and finally emits one result
// per cycle while the receiver is ready.
// Add edge and clear transactions are taken one per cycle while idle.
// Every scan step waits on the registered read of the edge RAM.
// Reset is synchronous; it empties the edge store and restores 64 vertices.
// ---------------------------------------------------------------------------
// SCC top level
// Kosaraju component finder built around one edge scan unit and a sequencer.
// ---------------------------------------------------------------------------
module strongly_connected_components_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  logic [5:0] req_edge_from,
   input  logic [5:0] req_edge_to,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [5:0] rsp_vertex_index,
   output logic [6:0] rsp_component_number,
   output logic       rsp_edges_dropped,
   output logic       rsp_last
);
   localparam int VW = scc_pkg::VW;
   localparam int EW = scc_pkg::EW;
   localparam int CW = scc_pkg::CW;

   scc_pkg::state_type state_ff, state_in;
   logic [6:0]    count_ff;
   logic [CW-1:0] stored_ff, stored_in;
   logic          drop_ff, drop_in;
   logic [VW:0]   n_act;

   // One visited flag per vertex, cleared at the start of each pass.
   logic [scc_pkg::MaxVertices-1:0] seen_ff, seen_in;

   logic [VW:0]   sp_ff, sp_in;
   logic [VW:0]   fcnt_ff, fcnt_in;
   logic [VW:0]   vi_ff, vi_in;
   logic [CW-1:0] c_ff, c_in;
   logic [CW-1:0] p_ff, p_in;
   logic          pass2_ff, pass2_in;
   logic [6:0]    ccnt_ff, ccnt_in;
   logic [VW-1:0] top_v_ff, top_v_in;

   // Edge RAM and its read port.
   logic [EW-1:0]   rd_addr;
   logic [2*VW-1:0] rd_data;
   logic            wr_en;
   logic [VW-1:0]   es, ed;

   // Source-sorted edge order, finish order, saved stack frames and labels.
   logic             bys_set;
   logic [EW-1:0]    bys_rd;
   logic             fin_set;
   logic [VW-1:0]    fin_rd;
   logic             push;
   logic [VW+CW-1:0] stk_rd;
   logic             comp_set;
   logic [VW-1:0]    comp_addr;
   logic [6:0]       comp_rd;

   logic          hit;
   logic [VW-1:0] w;

   assign es = rd_data[2*VW-1:VW];
   assign ed = rd_data[VW-1:0];

   always_comb begin
      n_act = (count_ff == 7'd0) ? (VW+1)'(1) :
              (count_ff > 7'(scc_pkg::MaxVertices)) ? (VW+1)'(scc_pkg::MaxVertices) :
              (VW+1)'(count_ff);
   end

   assign wr_en = req_valid && req_ready &&
                  (scc_pkg::opcode_type'(req_opcode) == scc_pkg::OP_ADD) &&
                  ((VW+1)'(req_edge_from) < n_act) && ((VW+1)'(req_edge_to) < n_act) &&
                  (stored_ff < CW'(scc_pkg::MaxEdges));

   // Pass two reaches each edge through the sorted order list first.
   assign rd_addr = (state_ff == scc_pkg::S_SCAN_IDX) ? bys_rd : c_ff[EW-1:0];

   scc_edge_ram #(.Depth(scc_pkg::MaxEdges), .Width(2*VW)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(stored_ff[EW-1:0]),
      .wr_data({req_edge_from, req_edge_to}),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   scc_edge_ram #(.Depth(scc_pkg::MaxEdges), .Width(EW)) u_order_ram (
      .clock  (clock),
      .wr_en  (bys_set),
      .wr_addr(p_ff[EW-1:0]),
      .wr_data(c_ff[EW-1:0]),
      .rd_addr(c_ff[EW-1:0]),
      .rd_data(bys_rd)
   );

   scc_edge_ram #(.Depth(scc_pkg::MaxVertices), .Width(VW)) u_finish_ram (
      .clock  (clock),
      .wr_en  (fin_set),
      .wr_addr(fcnt_ff[VW-1:0]),
      .wr_data(top_v_ff),
      .rd_addr(fcnt_ff[VW-1:0] - VW'(1)),
      .rd_data(fin_rd)
   );

   // The top frame lives in top_v_ff and c_ff; parent frames are saved here.
   scc_edge_ram #(.Depth(scc_pkg::MaxVertices), .Width(VW+CW)) u_stack_ram (
      .clock  (clock),
      .wr_en  (push),
      .wr_addr(sp_ff[VW-1:0] - VW'(1)),
      .wr_data({top_v_ff, c_ff + CW'(1)}),
      .rd_addr(sp_ff[VW-1:0] - VW'(2)),
      .rd_data(stk_rd)
   );

   scc_edge_ram #(.Depth(scc_pkg::MaxVertices), .Width(7)) u_comp_ram (
      .clock  (clock),
      .wr_en  (comp_set),
      .wr_addr(comp_addr),
      .wr_data(ccnt_in),
      .rd_addr(vi_in[VW-1:0]),
      .rd_data(comp_rd)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scc_pkg::S_IDLE;
         count_ff <= 7'd64;
         stored_ff <= '0;
         drop_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stored_ff <= stored_in;
         drop_ff <= drop_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   // Walk registers.
   always_ff @(posedge clock) begin
      sp_ff <= sp_in;
      fcnt_ff <= fcnt_in;
      vi_ff <= vi_in;
      c_ff <= c_in;
      p_ff <= p_in;
      pass2_ff <= pass2_in;
      ccnt_ff <= ccnt_in;
      top_v_ff <= top_v_in;
      seen_ff <= seen_in;
   end

   // Sequencer: idle request handling, then sort, first pass, second pass, emit.
   always_comb begin
      state_in = state_ff;
      stored_in = stored_ff;
      drop_in = drop_ff;
      sp_in = sp_ff;
      fcnt_in = fcnt_ff;
      vi_in = vi_ff;
      c_in = c_ff;
      p_in = p_ff;
      pass2_in = pass2_ff;
      ccnt_in = ccnt_ff;
      top_v_in = top_v_ff;
      seen_in = seen_ff;
      comp_set = 1'b0;
      comp_addr = '0;
      fin_set = 1'b0;
      push = 1'b0;
      bys_set = 1'b0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      w = pass2_ff ? es : ed;
      hit = ((VW+1)'(es) < n_act) && ((VW+1)'(ed) < n_act) &&
            ((pass2_ff ? ed : es) == top_v_ff) && !seen_ff[w];
      unique case (state_ff)
         scc_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (scc_pkg::opcode_type'(req_opcode))
                  scc_pkg::OP_ADD: begin
                     if (!wr_en) drop_in = 1'b1;
                     else stored_in = stored_ff + CW'(1);
                  end
                  scc_pkg::OP_CLEAR: begin
                     stored_in = '0;
                     drop_in = 1'b0;
                  end
                  scc_pkg::OP_RUN: begin
                     state_in = scc_pkg::S_SORT;
                     vi_in = '0;
                     c_in = '0;
                     p_in = '0;
                     pass2_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         scc_pkg::S_SORT: begin
            if (c_ff >= stored_ff) begin
               c_in = '0;
               if (vi_ff == (VW+1)'(scc_pkg::MaxVertices - 1)) begin
                  state_in = scc_pkg::S_P1_ROOT;
                  vi_in = '0;
                  seen_in = '0;
                  fcnt_in = '0;
                  sp_in = '0;
               end else begin
                  vi_in = vi_ff + (VW+1)'(1);
               end
            end else begin
               state_in = scc_pkg::S_SORT_WAIT;
            end
         end
         scc_pkg::S_SORT_WAIT: begin
            if (es == vi_ff[VW-1:0]) begin
               bys_set = 1'b1;
               p_in = p_ff + CW'(1);
            end
            c_in = c_ff + CW'(1);
            state_in = scc_pkg::S_SORT;
         end
         scc_pkg::S_P1_ROOT: begin
            if (vi_ff >= n_act) begin
               state_in = scc_pkg::S_P2_CLR;
            end else begin
               vi_in = vi_ff + (VW+1)'(1);
               if (!seen_ff[vi_ff[VW-1:0]]) begin
                  seen_in[vi_ff[VW-1:0]] = 1'b1;
                  top_v_in = vi_ff[VW-1:0];
                  c_in = '0;
                  sp_in = (VW+1)'(1);
                  state_in = scc_pkg::S_SCAN;
               end
            end
         end
         scc_pkg::S_TOP: begin
            // Resume the parent frame read back from the stack RAM.
            top_v_in = stk_rd[VW+CW-1:CW];
            c_in = stk_rd[CW-1:0];
            state_in = scc_pkg::S_SCAN;
         end
         scc_pkg::S_SCAN: begin
            if (c_ff >= stored_ff) begin
               if (!pass2_ff) begin
                  fin_set = 1'b1;
                  fcnt_in = fcnt_ff + (VW+1)'(1);
               end
               sp_in = sp_ff - (VW+1)'(1);
               if (sp_ff == (VW+1)'(1)) begin
                  state_in = pass2_ff ? scc_pkg::S_P2_ROOT : scc_pkg::S_P1_ROOT;
               end else begin
                  state_in = scc_pkg::S_TOP;
               end
            end else begin
               state_in = pass2_ff ? scc_pkg::S_SCAN_IDX : scc_pkg::S_SCAN_WAIT;
            end
         end
         scc_pkg::S_SCAN_IDX: begin
            state_in = scc_pkg::S_SCAN_WAIT;
         end
         scc_pkg::S_SCAN_WAIT: begin
            if (hit) begin
               push = 1'b1;
               seen_in[w] = 1'b1;
               comp_set = pass2_ff;
               comp_addr = w;
               top_v_in = w;
               c_in = '0;
               sp_in = sp_ff + (VW+1)'(1);
            end else begin
               c_in = c_ff + CW'(1);
            end
            state_in = scc_pkg::S_SCAN;
         end
         scc_pkg::S_P2_CLR: begin
            seen_in = '0;
            ccnt_in = '0;
            pass2_in = 1'b1;
            state_in = scc_pkg::S_P2_ROOT;
         end
         scc_pkg::S_P2_ROOT: begin
            if (fcnt_ff == '0) begin
               state_in = scc_pkg::S_EMIT;
               vi_in = '0;
            end else begin
               fcnt_in = fcnt_ff - (VW+1)'(1);
               state_in = scc_pkg::S_P2_ROOT_WAIT;
            end
         end
         scc_pkg::S_P2_ROOT_WAIT: begin
            // The finish order entry read in the previous cycle is the next root.
            if (!seen_ff[fin_rd]) begin
               ccnt_in = ccnt_ff + 7'd1;
               seen_in[fin_rd] = 1'b1;
               comp_set = 1'b1;
               comp_addr = fin_rd;
               top_v_in = fin_rd;
               c_in = '0;
               sp_in = (VW+1)'(1);
               state_in = scc_pkg::S_SCAN;
            end else begin
               state_in = scc_pkg::S_P2_ROOT;
            end
         end
         scc_pkg::S_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               vi_in = vi_ff + (VW+1)'(1);
               if (vi_ff + (VW+1)'(1) == n_act) state_in = scc_pkg::S_IDLE;
            end
         end
         default: state_in = scc_pkg::S_IDLE;
      endcase
   end

   assign rsp_vertex_index = vi_ff[VW-1:0];
   assign rsp_component_number = comp_rd;
   assign rsp_edges_dropped = drop_ff;
   assign rsp_last = (vi_ff + (VW+1)'(1) == n_act);
endmodule

### rtl/core/scc_checker.sv
// ---------------------------------------------------------------------------
// SCC port checker
// Watches the top-level ports for the result handshake, result values and the return to idle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module scc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [5:0] rsp_vertex_index,
   input logic [6:0] rsp_component_number,
   input logic       rsp_last
);
   // A result holds while it waits.
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_vertex_index))
   // The block never takes a transaction while a result is pending.
   `ASSERT_IMPLY(a_excl, clock, reset, rsp_valid, !req_ready)
   // Every component number is at least one.
   `ASSERT_IMPLY(a_comp, clock, reset, rsp_valid, rsp_component_number != 7'd0)
   // After the final result the block returns to accepting work.
   `ASSERT_NEXT(a_done, clock, reset, rsp_valid && rsp_ready && rsp_last, req_ready)
endmodule

bind strongly_connected_components_top scc_checker u_scc_checker (.*);
